/* hw/rtl/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

	localparam int HUE_BITS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int SAT_BITS  = 17;

	// 1.0 in the 1.16 saturation format
	localparam logic [SAT_BITS-1:0] SAT_ONE = 17'h1_0000;
	// 1.0 in the 1.32 product format used for q and t
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	// hue sector, each one sixth of a turn
	typedef enum logic [2:0] {
		SEC_RED = 3'd0,
		SEC_YEL = 3'd1,
		SEC_GRN = 3'd2,
		SEC_CYN = 3'd3,
		SEC_BLU = 3'd4,
		SEC_MAG = 3'd5
	} sector_t;

endpackage

/* hw/rtl/hsv_if.sv */
interface hsv_if import hsv2rgb_pkg::*; #(
	parameter int CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [HUE_BITS-1:0]     hue_frac;
	logic [SAT_BITS-1:0]     sat_level;
	logic [CHANNEL_BITS-1:0] val_level;

	modport source (output valid, output hue_frac, output sat_level, output val_level,
		input ready);
	modport sink (input valid, input hue_frac, input sat_level, input val_level,
		output ready);
endinterface

/* hw/rtl/rgb_if.sv */
interface rgb_if #(
	parameter int CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_out;
	logic [CHANNEL_BITS-1:0] green_out;
	logic [CHANNEL_BITS-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

/* hw/rtl/hsv_to_rgb_converter.sv */
// channel  dir  payload                               handshake
// hsv      in   hue_frac, sat_level, val_level        valid / ready
// rgb      out  red_out, green_out, blue_out          valid / ready
//
// four register stages; one word enters per cycle while hsv.ready is high,
// and its result leaves from the stage 4 output register
// arst_n clears the stage valid bits only; no state survives an item
// each stage advances when empty or when the stage after it moves, so a
// stall on rgb fills the bubbles first and only then drops hsv.ready
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	hsv_if.sink    hsv,
	rgb_if.source  rgb
);

	localparam int CB = CHANNEL_BITS;
	// width of V * (1 - S)
	localparam int PW = CB + SAT_BITS;
	// width of V * (1.32 complement)
	localparam int QW = CB + 33;

	// stage advance enables, back to front
	logic adv1, adv2, adv3, adv4;
	logic v1_s1, v2_s2, v3_s3, v4_s4;

	assign adv4      = !v4_s4 || rgb.ready;
	assign adv3      = !v3_s3 || adv4;
	assign adv2      = !v2_s2 || adv3;
	assign adv1      = !v1_s1 || adv2;
	assign hsv.ready = adv1;

	// ---------------- stage 1: clamp saturation, split hue ----------------
	logic [SAT_BITS-1:0]  sat_clamp;
	logic [HUE_BITS+2:0]  h6;

	sector_t              sec_s1;
	logic [FRAC_BITS-1:0] f_s1;
	logic [SAT_BITS-1:0]  sat_s1;
	logic [CB-1:0]        val_s1;

	// saturation above one is taken as one
	assign sat_clamp = (hsv.sat_level > SAT_ONE) ? SAT_ONE : hsv.sat_level;
	// hue * 6 as 4x + 2x; top three bits are the sector, low 16 the fraction
	assign h6 = ({3'd0, hsv.hue_frac} << 2) + ({3'd0, hsv.hue_frac} << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (adv1) begin
			v1_s1 <= hsv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && hsv.valid) begin
			sec_s1 <= sector_t'(h6[HUE_BITS+2:HUE_BITS]);
			f_s1   <= h6[FRAC_BITS-1:0];
			sat_s1 <= sat_clamp;
			val_s1 <= hsv.val_level;
		end
	end

	// ---------------- stage 2: S*f, S*(1-f) and p ----------------
	// zero saturation needs no special path: p, q and t all equal V then
	logic [SAT_BITS-1:0] one_m_f;
	logic [SAT_BITS-1:0] one_m_s;
	logic [32:0]         sf;
	logic [33:0]         sg;
	logic [33:0]         ct_full;
	logic [PW-1:0]       p_prod;

	sector_t             sec_s2;
	logic [CB-1:0]       val_s2;
	logic [CB-1:0]       p_s2;
	logic [32:0]         cq_s2;
	logic [32:0]         ct_s2;

	assign one_m_f = SAT_ONE - {1'b0, f_s1};
	assign one_m_s = SAT_ONE - sat_s1;
	assign sf      = {16'd0, sat_s1} * {17'd0, f_s1};
	assign sg      = {17'd0, sat_s1} * {17'd0, one_m_f};
	// sg never exceeds 2^32, so the complement fits in 33 bits
	assign ct_full = {1'b0, ONE_Q32} - sg;
	assign p_prod  = PW'(val_s1) * PW'(one_m_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (adv2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_s1) begin
			sec_s2 <= sec_s1;
			val_s2 <= val_s1;
			p_s2   <= p_prod[CB+15:16];
			cq_s2  <= ONE_Q32 - sf;
			ct_s2  <= ct_full[32:0];
		end
	end

	// ---------------- stage 3: q and t ----------------
	logic [QW-1:0] q_prod;
	logic [QW-1:0] t_prod;

	sector_t       sec_s3;
	logic [CB-1:0] val_s3;
	logic [CB-1:0] p_s3;
	logic [CB-1:0] q_s3;
	logic [CB-1:0] t_s3;

	assign q_prod = QW'(val_s2) * QW'(cq_s2);
	assign t_prod = QW'(val_s2) * QW'(ct_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (adv3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v2_s2) begin
			sec_s3 <= sec_s2;
			val_s3 <= val_s2;
			p_s3   <= p_s2;
			q_s3   <= q_prod[CB+31:32];
			t_s3   <= t_prod[CB+31:32];
		end
	end

	// ---------------- stage 4: sector routing into the output register ----------------
	logic [CB-1:0] r_sel, g_sel, b_sel;
	logic [CB-1:0] r_s4, g_s4, b_s4;

	always_comb begin
		unique case (sec_s3)
			SEC_RED: begin r_sel = val_s3; g_sel = t_s3;   b_sel = p_s3;   end
			SEC_YEL: begin r_sel = q_s3;   g_sel = val_s3; b_sel = p_s3;   end
			SEC_GRN: begin r_sel = p_s3;   g_sel = val_s3; b_sel = t_s3;   end
			SEC_CYN: begin r_sel = p_s3;   g_sel = q_s3;   b_sel = val_s3; end
			SEC_BLU: begin r_sel = t_s3;   g_sel = p_s3;   b_sel = val_s3; end
			default: begin r_sel = val_s3; g_sel = p_s3;   b_sel = q_s3;   end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_s4 <= 1'b0;
		end else if (adv4) begin
			v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v3_s3) begin
			r_s4 <= r_sel;
			g_s4 <= g_sel;
			b_s4 <= b_sel;
		end
	end

	assign rgb.valid     = v4_s4;
	assign rgb.red_out   = r_s4;
	assign rgb.green_out = g_s4;
	assign rgb.blue_out  = b_s4;

	// ---------------- checks ----------------
	// input back-pressure only when every stage is full and the sink stalls
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv.ready |-> (v1_s1 && v2_s2 && v3_s3 && v4_s4 && !rgb.ready))
		else $error("input stalled with a bubble in the pipeline");

	// a new output word comes only from a valid stage 3
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v4_s4) |-> $past(v3_s3))
		else $error("output word appeared without a source");

	// p, q and t scale V down, never up
	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 |-> (p_s3 <= val_s3 && q_s3 <= val_s3 && t_s3 <= val_s3))
		else $error("channel term exceeds value");

endmodule
